// File: hw/rtl/tetrahedron_quaternion_rotator_core_macros.svh
// Assertion macros for the tetrahedron quaternion rotator.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TETRAHEDRON_QUATERNION_ROTATOR_CORE_MACROS_SVH
`define TETRAHEDRON_QUATERNION_ROTATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define TQR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tqr assertion failed");

// Next-cycle implication.
`define TQR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tqr assertion failed");

`endif

// File: hw/rtl/tqr_pkg.sv
// Shared types and constants of the tetrahedron quaternion rotator.
// No dependencies; used by every module of the block.
package tqr_pkg;

	localparam int TQR_QW = 16;             // quaternion component width
	localparam int TQR_PW = 32;             // position width
	localparam int TQR_HW = 31;             // half offset width
	localparam int TQR_SW = 33;             // sum of squares width
	localparam int TQR_NW = 34;             // matrix numerator / axis sum width
	localparam int TQR_MW = 33;             // axis sum magnitude width
	localparam int TQR_DW = 64;             // dividend width
	localparam int TQR_QUOW = 32;           // quotient width
	localparam int TQR_LANE_LAT = TQR_QUOW + 2;
	localparam int TQR_ATOMS = 4;
	localparam int TQR_AW = 2;
	localparam int TQR_AXES = 3;
	localparam int TQR_QUEUE_DEPTH = 4;

	localparam logic [TQR_HW-1:0] TQR_HALF_RESET = 31'd9813;

	// Offset sign per hydrogen and axis, set bit = negative.
	localparam logic [TQR_ATOMS-1:0][TQR_AXES-1:0] TQR_NEG =
		{3'b100, 3'b001, 3'b010, 3'b111};

	typedef struct packed {
		logic signed [TQR_QW-1:0] quat_w;
		logic signed [TQR_QW-1:0] quat_x;
		logic signed [TQR_QW-1:0] quat_y;
		logic signed [TQR_QW-1:0] quat_z;
		logic signed [TQR_PW-1:0] center_x;
		logic signed [TQR_PW-1:0] center_y;
		logic signed [TQR_PW-1:0] center_z;
	} tqr_item_t;

	typedef struct packed {
		logic [TQR_AW-1:0]        atom_index;
		logic signed [TQR_PW-1:0] pos_x;
		logic signed [TQR_PW-1:0] pos_y;
		logic signed [TQR_PW-1:0] pos_z;
		logic                     degenerate;
		logic                     last;
	} tqr_result_t;

	typedef struct packed {
		logic [TQR_SW-1:0]                             s;
		logic                                          deg;
		logic [TQR_AXES-1:0][TQR_PW-1:0]               ctr;
		logic [TQR_AXES-1:0][TQR_AXES-1:0][TQR_NW-1:0] n;
	} tqr_entry_t;

	typedef struct packed {
		logic [TQR_AXES-1:0][TQR_PW-1:0] ctr;
		logic                            deg;
		logic                            last;
		logic [TQR_AW-1:0]               idx;
	} tqr_side_t;

endpackage

// File: hw/rtl/tqr_front.sv
// Front end: accepts molecules, forms the rotation matrix numerators
// and the sum of squares in two stages. Depends on tqr_pkg.
module tqr_front #(
	parameter int QDEPTH = tqr_pkg::TQR_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  tqr_pkg::tqr_item_t             item,
	input  logic [$clog2(QDEPTH+1)-1:0]    count,
	output logic                           push,
	output tqr_pkg::tqr_entry_t            entry
);
	import tqr_pkg::*;

	localparam int CW = $clog2(QDEPTH + 1);

	logic                  accept;
	logic                  v_s1, v_s2;
	logic [CW:0]           occ;
	logic signed [31:0]    ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0]    xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic [TQR_AXES-1:0][TQR_PW-1:0] ctr_s1;
	tqr_entry_t            ent_c, entry_s2;
	logic signed [TQR_NW-1:0] d_xy_m, d_xy_p, d_xz_p, d_xz_m, d_yz_m, d_yz_p;

	function automatic logic signed [TQR_NW-1:0] NW_ext(input logic signed [31:0] v);
		return TQR_NW'(v);
	endfunction

	// Stall on in-flight transactions too, so the queue never overflows.
	assign occ = (CW+1)'(count) + (CW+1)'(v_s1) + (CW+1)'(v_s2);
	assign item_stall = occ >= (CW+1)'(QDEPTH);
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (accept) begin
			ww_s1 <= item.quat_w * item.quat_w;
			xx_s1 <= item.quat_x * item.quat_x;
			yy_s1 <= item.quat_y * item.quat_y;
			zz_s1 <= item.quat_z * item.quat_z;
			xy_s1 <= item.quat_x * item.quat_y;
			wz_s1 <= item.quat_w * item.quat_z;
			xz_s1 <= item.quat_x * item.quat_z;
			wy_s1 <= item.quat_w * item.quat_y;
			yz_s1 <= item.quat_y * item.quat_z;
			wx_s1 <= item.quat_w * item.quat_x;
			ctr_s1 <= {item.center_z, item.center_y, item.center_x};
		end
	end

	always_comb begin
		d_xy_m = NW_ext(xy_s1) - NW_ext(wz_s1);
		d_xy_p = NW_ext(xy_s1) + NW_ext(wz_s1);
		d_xz_p = NW_ext(xz_s1) + NW_ext(wy_s1);
		d_xz_m = NW_ext(xz_s1) - NW_ext(wy_s1);
		d_yz_m = NW_ext(yz_s1) - NW_ext(wx_s1);
		d_yz_p = NW_ext(yz_s1) + NW_ext(wx_s1);
		ent_c.s = TQR_SW'(ww_s1) + TQR_SW'(xx_s1) + TQR_SW'(yy_s1) + TQR_SW'(zz_s1);
		ent_c.deg = (ent_c.s == '0);
		ent_c.ctr = ctr_s1;
		ent_c.n[0][0] = NW_ext(ww_s1) + NW_ext(xx_s1) - NW_ext(yy_s1) - NW_ext(zz_s1);
		ent_c.n[0][1] = {d_xy_m[TQR_NW-2:0], 1'b0};
		ent_c.n[0][2] = {d_xz_p[TQR_NW-2:0], 1'b0};
		ent_c.n[1][0] = {d_xy_p[TQR_NW-2:0], 1'b0};
		ent_c.n[1][1] = NW_ext(ww_s1) - NW_ext(xx_s1) + NW_ext(yy_s1) - NW_ext(zz_s1);
		ent_c.n[1][2] = {d_yz_m[TQR_NW-2:0], 1'b0};
		ent_c.n[2][0] = {d_xz_m[TQR_NW-2:0], 1'b0};
		ent_c.n[2][1] = {d_yz_p[TQR_NW-2:0], 1'b0};
		ent_c.n[2][2] = NW_ext(ww_s1) - NW_ext(xx_s1) - NW_ext(yy_s1) + NW_ext(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			entry_s2 <= ent_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign push = v_s2;
	assign entry = entry_s2;

endmodule

// File: hw/rtl/tqr_queue.sv
// Short queue of prepared molecules between front and back end.
// Depends on tqr_pkg for the entry type.
module tqr_queue #(
	parameter int QDEPTH = tqr_pkg::TQR_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  tqr_pkg::tqr_entry_t         push_data,
	input  logic                        pop,
	output tqr_pkg::tqr_entry_t         head,
	output logic [$clog2(QDEPTH+1)-1:0] count
);
	import tqr_pkg::*;

	localparam int IW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	tqr_entry_t      mem_q [QDEPTH];
	logic [IW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == IW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == IW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head = mem_q[rd_q];
	assign count = cnt_q;

endmodule

// File: hw/rtl/tqr_div_lane.sv
// One axis lane: scales |T| by the half offset, adds half the divisor
// and divides by the sum of squares, one quotient bit per stage. Uses tqr_pkg.
module tqr_div_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic [tqr_pkg::TQR_HW-1:0]        h,
	input  logic [tqr_pkg::TQR_SW-1:0]        s,
	input  logic signed [tqr_pkg::TQR_NW-1:0] t,
	output logic [tqr_pkg::TQR_QUOW-1:0]      q,
	output logic                              neg
);
	import tqr_pkg::*;

	logic [TQR_MW-1:0]   mag;
	logic [TQR_DW-1:0]   prod_s1;
	logic [TQR_DW-1:0]   dvd;
	logic [TQR_SW-1:0]   s_s1;
	logic                neg_s1;
	logic [TQR_SW-1:0]   rem_s  [TQR_QUOW+1];
	logic [TQR_QUOW-1:0] lo_s   [TQR_QUOW+1];
	logic [TQR_SW-1:0]   div_s  [TQR_QUOW+1];
	logic                neg_s  [TQR_QUOW+1];
	logic [TQR_SW-1:0]   rem_nx [TQR_QUOW];
	logic                ge_nx  [TQR_QUOW];

	assign mag = t[TQR_NW-1] ? TQR_MW'(-t) : TQR_MW'(t);
	assign dvd = prod_s1 + TQR_DW'(s_s1 >> 1);

	// Restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		logic [TQR_SW:0] trial;
		for (int g = 0; g < TQR_QUOW; g++) begin
			trial = {rem_s[g], lo_s[g][TQR_QUOW-1]};
			ge_nx[g] = trial >= {1'b0, div_s[g]};
			rem_nx[g] = ge_nx[g] ? TQR_SW'(trial - {1'b0, div_s[g]}) : TQR_SW'(trial);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= h * mag;
			s_s1 <= s;
			neg_s1 <= t[TQR_NW-1];
			rem_s[0] <= TQR_SW'(dvd[TQR_DW-1:TQR_QUOW]);
			lo_s[0] <= dvd[TQR_QUOW-1:0];
			div_s[0] <= s_s1;
			neg_s[0] <= neg_s1;
			for (int g = 0; g < TQR_QUOW; g++) begin
				rem_s[g+1] <= rem_nx[g];
				lo_s[g+1] <= {lo_s[g][TQR_QUOW-2:0], ge_nx[g]};
				div_s[g+1] <= div_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	assign q = lo_s[TQR_QUOW];
	assign neg = neg_s[TQR_QUOW];

endmodule

// File: hw/rtl/tqr_back.sv
// Back end: unless stalled, issues one hydrogen per cycle from the queue head
// via three divider lanes, adds centre, saturates. Uses tqr_pkg, tqr_div_lane.
module tqr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tqr_pkg::TQR_HW-1:0] half_offset,
	input  tqr_pkg::tqr_entry_t        head,
	input  logic                       head_valid,
	output logic                       pop,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tqr_pkg::tqr_result_t       result
);
	import tqr_pkg::*;

	logic                              en, issue;
	logic [TQR_AW-1:0]                 k_q;
	logic [TQR_AXES-1:0][TQR_NW-1:0]   t_nx, t_s1;
	logic [TQR_SW-1:0]                 s_s1;
	tqr_side_t                         side_s [TQR_LANE_LAT+1];
	logic                              vld_s  [TQR_LANE_LAT+1];
	logic [TQR_QUOW-1:0]               lane_q   [TQR_AXES];
	logic                              lane_neg [TQR_AXES];
	logic [TQR_AXES-1:0][TQR_PW-1:0]   pos_c;
	logic                              res_valid_q;
	tqr_result_t                       res_q;
	tqr_side_t                         side_in;

	// Whole back pipe advances unless a finished result is held.
	assign en = !res_valid_q || !result_stall;
	assign issue = en && head_valid;
	assign pop = issue && (k_q == TQR_AW'(TQR_ATOMS - 1));

	always_comb begin
		logic signed [TQR_NW+1:0] acc, term;
		for (int a = 0; a < TQR_AXES; a++) begin
			acc = '0;
			for (int j = 0; j < TQR_AXES; j++) begin
				term = (TQR_NW+2)'($signed(head.n[a][j]));
				if (TQR_NEG[k_q][j]) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			t_nx[a] = acc[TQR_NW-1:0];
		end
	end

	assign side_in = '{ctr: head.ctr, deg: head.deg,
		last: (k_q == TQR_AW'(TQR_ATOMS - 1)), idx: k_q};

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_nx;
			s_s1 <= head.s;
			side_s[0] <= side_in;
			for (int m = 0; m < TQR_LANE_LAT; m++) begin
				side_s[m+1] <= side_s[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			for (int m = 0; m <= TQR_LANE_LAT; m++) begin
				vld_s[m] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= (k_q == TQR_AW'(TQR_ATOMS - 1)) ? '0 : k_q + 1'b1;
			end
			if (en) begin
				vld_s[0] <= head_valid;
				for (int m = 0; m < TQR_LANE_LAT; m++) begin
					vld_s[m+1] <= vld_s[m];
				end
				res_valid_q <= vld_s[TQR_LANE_LAT];
			end
		end
	end

	for (genvar a = 0; a < TQR_AXES; a++) begin : g_lane
		tqr_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.h   (half_offset),
			.s   (s_s1),
			.t   ($signed(t_s1[a])),
			.q   (lane_q[a]),
			.neg (lane_neg[a])
		);
	end

	always_comb begin
		logic signed [TQR_PW+1:0] sum, off;
		for (int a = 0; a < TQR_AXES; a++) begin
			off = $signed({2'b00, lane_q[a]});
			if (lane_neg[a]) begin
				off = -off;
			end
			sum = (TQR_PW+2)'($signed(side_s[TQR_LANE_LAT].ctr[a])) + off;
			if (side_s[TQR_LANE_LAT].deg) begin
				pos_c[a] = side_s[TQR_LANE_LAT].ctr[a];
			end else if (sum[TQR_PW+1:TQR_PW-1] == 3'b000
				|| sum[TQR_PW+1:TQR_PW-1] == 3'b111) begin
				pos_c[a] = sum[TQR_PW-1:0];
			end else if (sum[TQR_PW+1]) begin
				pos_c[a] = {1'b1, {(TQR_PW-1){1'b0}}};
			end else begin
				pos_c[a] = {1'b0, {(TQR_PW-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.atom_index <= side_s[TQR_LANE_LAT].idx;
			res_q.pos_x <= pos_c[0];
			res_q.pos_y <= pos_c[1];
			res_q.pos_z <= pos_c[2];
			res_q.degenerate <= side_s[TQR_LANE_LAT].deg;
			res_q.last <= side_s[TQR_LANE_LAT].last;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

// File: hw/rtl/tetrahedron_quaternion_rotator_core.sv
// Path: a molecule passes the front stages and the queue; new molecules are taken
// while earlier ones are in flight. The back end issues one hydrogen per cycle,
// unless a result is held or the queue is empty, into three 34-stage divider lanes.
// Reset: arst_n clears queue, counters and valid flags at once and sets
// half_offset to 9813; datapath registers are not reset.
// Depends on tqr_pkg, tqr_front, tqr_queue, tqr_back and the macros header.
`include "tetrahedron_quaternion_rotator_core_macros.svh"

module tetrahedron_quaternion_rotator_core #(
	parameter int QDEPTH = tqr_pkg::TQR_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  tqr_pkg::tqr_item_t         item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output tqr_pkg::tqr_result_t       result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tqr_pkg::TQR_HW-1:0] cfg_data
);
	import tqr_pkg::*;

	localparam int CW = $clog2(QDEPTH + 1);

	logic [TQR_HW-1:0] half_offset_q;
	logic              q_push, q_pop;
	tqr_entry_t        q_in, q_head;
	logic [CW-1:0]     q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_offset_q <= TQR_HALF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_offset_q <= cfg_data;
		end
	end

	tqr_front #(.QDEPTH(QDEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.count      (q_count),
		.push       (q_push),
		.entry      (q_in)
	);

	tqr_queue #(.QDEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.count     (q_count)
	);

	tqr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.half_offset  (half_offset_q),
		.head         (q_head),
		.head_valid   (q_count != '0),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`TQR_ASSERT_IMPL(a_no_overflow, q_push, q_count != CW'(QDEPTH))
	`TQR_ASSERT_IMPL(a_pop_nonempty, q_pop, q_count != '0)
	`TQR_ASSERT_IMPL(a_empty_takes, q_count == '0, !item_stall)
	`TQR_ASSERT_IMPL(a_last_index, result_valid && result.last, result.atom_index == 2'd3)

endmodule

// File: tb/sv/tetrahedron_quaternion_rotator_core_tb.sv
// Self-checking bench for tetrahedron_quaternion_rotator_core: predicts the four hydrogen
// positions per molecule and compares every result transaction in order.
// Depends on tqr_pkg and the core RTL.
module tetrahedron_quaternion_rotator_core_tb;
	import tqr_pkg::*;

	localparam int LAT = 41;
	localparam longint LIMIT = 400000;

	class hydrogen_board;
		tqr_result_t pending[$];
		logic [30:0] half;
		int errors;

		function new();
			half = TQR_HALF_RESET;
			errors = 0;
		endfunction

		// h*t/s, rounded half away from zero
		function longint scaled(longint t, longint s);
			logic [63:0] mag, q;
			mag = (t < 0) ? -t : t;
			q = (64'(half) * mag + 64'(s / 2)) / 64'(s);
			return (t < 0) ? -longint'(q) : longint'(q);
		endfunction

		function void note_molecule(tqr_item_t it);
			longint w, x, y, z, s, t, p;
			longint n[3][3];
			longint c[3];
			tqr_result_t r;
			w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
			c[0] = it.center_x; c[1] = it.center_y; c[2] = it.center_z;
			s = w*w + x*x + y*y + z*z;
			n[0][0] = w*w + x*x - y*y - z*z;
			n[0][1] = 2*(x*y - w*z);
			n[0][2] = 2*(x*z + w*y);
			n[1][0] = 2*(x*y + w*z);
			n[1][1] = w*w - x*x + y*y - z*z;
			n[1][2] = 2*(y*z - w*x);
			n[2][0] = 2*(x*z - w*y);
			n[2][1] = 2*(y*z + w*x);
			n[2][2] = w*w - x*x - y*y + z*z;
			for (int k = 0; k < 4; k++) begin
				longint pos[3];
				for (int i = 0; i < 3; i++) begin
					p = c[i];
					if (s != 0) begin
						t = 0;
						for (int j = 0; j < 3; j++)
							t += TQR_NEG[k][j] ? -n[i][j] : n[i][j];
						p = c[i] + scaled(t, s);
						if (p > 64'sd2147483647) p = 64'sd2147483647;
						if (p < -64'sd2147483648) p = -64'sd2147483648;
					end
					pos[i] = p;
				end
				r.atom_index = k[1:0];
				r.pos_x = pos[0][31:0];
				r.pos_y = pos[1][31:0];
				r.pos_z = pos[2][31:0];
				r.degenerate = (s == 0);
				r.last = (k == 3);
				pending.push_back(r);
			end
		endfunction

		function void check_hydrogen(tqr_result_t got);
			tqr_result_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display("result diff: exp %h got %h", exp, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic item_valid = 0, item_stall, result_valid, result_stall = 0;
	logic cfg_valid = 0, cfg_ready;
	logic [TQR_HW-1:0] cfg_data = '0;
	tqr_item_t item = '0;
	tqr_result_t result;
	hydrogen_board board;
	bit quiet = 0;
	longint cycles = 0;

	tetrahedron_quaternion_rotator_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tetrahedron_quaternion_rotator_core: mismatch");
			$finish;
		end
		if (arst_n && result_valid && !result_stall) board.check_hydrogen(result);
	end

	// receiver stalls in random bursts
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				result_stall <= 1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 0;
		end
	end

	task automatic write_half(logic [30:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.half = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic send_molecule(tqr_item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			item_valid <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end else
			@(negedge clk);
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (item_stall);
		board.note_molecule(it);
	endtask

	function automatic logic [15:0] rand_q();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 3)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_c();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + 32'($urandom_range(0, 100000));
			1: return 32'h7fff_ffff - 32'($urandom_range(0, 100000));
			default: return $urandom;
		endcase
	endfunction

	function automatic tqr_item_t rand_item();
		tqr_item_t it;
		it.quat_w = rand_q(); it.quat_x = rand_q();
		it.quat_y = rand_q(); it.quat_z = rand_q();
		if ($urandom_range(0, 19) == 0) it.quat_w = 0;
		it.center_x = rand_c(); it.center_y = rand_c(); it.center_z = rand_c();
		return it;
	endfunction

	initial begin
		tqr_item_t it;
		logic [30:0] halves[5];
		board = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: identity, axis turns, extremes, zero quaternion, centre extremes, random
		for (int d = 0; d < 12; d++) begin
			it = '0;
			case (d)
				0: it.quat_w = 16'sh7fff;
				1: it.quat_x = 16'sh7fff;
				2: it.quat_y = -16'sh8000;
				3: it.quat_z = 16'sh4000;
				4: begin
					it.quat_w = -16'sh8000; it.quat_x = -16'sh8000;
					it.quat_y = -16'sh8000; it.quat_z = -16'sh8000;
				end
				5: begin
					it.quat_w = 16'sh7fff; it.quat_x = 16'sh7fff;
					it.quat_y = 16'sh7fff; it.quat_z = 16'sh7fff;
				end
				6: ;
				7: begin
					it.center_x = 32'sh7fffffff; it.center_y = 32'sh80000000;
					it.center_z = -1;
				end
				8: begin
					it.quat_x = 1; it.center_x = 32'sh7fffffff;
					it.center_y = 32'sh80000000; it.center_z = 32'sh7fffff00;
				end
				9: begin
					it.quat_w = -1; it.quat_z = 1;
				end
				default: it = rand_item();
			endcase
			send_molecule(it);
		end
		@(negedge clk);
		item_valid <= 0;
		drain();

		halves = '{31'h7fffffff, 31'd0, 31'd1, 31'd65536, 31'd9813};
		for (int ph = 0; ph < 5; ph++) begin
			write_half(halves[ph]);
			if (ph == 4) quiet = 1;
			for (int k = 0; k < 90; k++) begin
				if (k == 45) begin
					@(negedge clk);
					item_valid <= 0;
					while (board.pending.size() != 0) @(posedge clk);
				end
				send_molecule(rand_item());
			end
			@(negedge clk);
			item_valid <= 0;
			drain();
		end
		if (board.errors == 0)
			$display("tetrahedron_quaternion_rotator_core: match");
		else
			$display("tetrahedron_quaternion_rotator_core: mismatch");
		$finish;
	end
endmodule
